// ----- rtl/ddo_pkg.sv -----
// Shared types, constants and tables for the differential drive odometry block.
package ddo_pkg;

  localparam int DDO_CORDIC_STEPS   = 20;
  localparam int DDO_POSITION_BITS  = 48;

  localparam logic [23:0] DPC_RESET = 24'd41177;
  localparam logic [23:0] IBW_RESET = 24'd131072;
  localparam logic [23:0] IP_RESET  = 24'd655360;

  localparam logic [31:0] BAM_PER_RAD = 32'd683565276;
  localparam int          CORDIC_GAIN = 652032874;
  localparam int          ONE_Q30     = 1073741824;

  typedef enum logic [1:0] {
    REG_DPC = 2'd0,
    REG_IBW = 2'd1,
    REG_IP  = 2'd2
  } ddo_reg_t;

  typedef struct packed {
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
  } ddo_in_t;

  typedef struct packed {
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic        [31:0] heading;
    logic signed [31:0] quat_z;
    logic signed [31:0] quat_w;
    logic signed [31:0] linear_rate;
    logic signed [31:0] angular_rate;
  } ddo_out_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIST_L,
    OP_DIST_R,
    OP_SUMDIFF,
    OP_CINIT,
    OP_CITER,
    OP_CFIN,
    OP_MUL,
    OP_MOVE_X,
    OP_MOVE_Y,
    OP_SAVE_P,
    OP_HEAD,
    OP_LIN,
    OP_ANG,
    OP_EMIT
  } ddo_op_t;

  typedef enum logic [1:0] {
    A_SUM,
    A_DIFF,
    A_P,
    A_HQ
  } ddo_asel_t;

  typedef enum logic [2:0] {
    B_COS,
    B_SIN,
    B_IBW,
    B_BAM,
    B_IP
  } ddo_bsel_t;

  typedef struct packed {
    ddo_op_t    op;
    ddo_asel_t  a_sel;
    ddo_bsel_t  b_sel;
    logic [1:0] chunk;
    logic       clear;
    logic       cnew;
    logic [4:0] step;
  } ddo_cmd_t;

  typedef struct packed {
    logic slot_free;
  } ddo_status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DL,
    S_DR,
    S_SUMDIFF,
    S_C1_INIT,
    S_C1_ITER,
    S_C1_FIN,
    S_MX0,
    S_MX1,
    S_MOVEX,
    S_MY0,
    S_MY1,
    S_MOVEY,
    S_P0,
    S_P1,
    S_SAVEP,
    S_H0,
    S_H1,
    S_HEAD,
    S_L0,
    S_L1,
    S_LIN,
    S_A0,
    S_A1,
    S_A2,
    S_ANG,
    S_C2_INIT,
    S_C2_ITER,
    S_C2_FIN,
    S_EMIT
  } ddo_state_t;

  // arctan(2^-i) as a binary angle, 2^32 per turn
  function automatic logic [31:0] atan_bam(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/ddo_ctrl.sv -----
// Sequencer for the odometry update: walks the datapath through each step.
module ddo_ctrl import ddo_pkg::*; #(
  parameter int CORDIC_STEPS = DDO_CORDIC_STEPS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  output logic        sample_stall,
  input  ddo_status_t status,
  output ddo_cmd_t    cmd
);

  localparam int CNT_W = $clog2(CORDIC_STEPS);

  ddo_state_t       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             last_step;

  assign last_step    = (cnt == CNT_W'(CORDIC_STEPS - 1));
  assign sample_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '{op: OP_NONE, a_sel: A_SUM, b_sel: B_COS, chunk: 2'd0,
                   clear: 1'b0, cnew: 1'b0, step: 5'(cnt)};
    unique case (state)
      S_IDLE: begin
        if (sample_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_DL;
        end
      end
      S_DL: begin
        cmd.op = OP_DIST_L; state_next = S_DR;
      end
      S_DR: begin
        cmd.op = OP_DIST_R; state_next = S_SUMDIFF;
      end
      S_SUMDIFF: begin
        cmd.op = OP_SUMDIFF; state_next = S_C1_INIT;
      end
      S_C1_INIT: begin
        cmd.op = OP_CINIT; cnt_next = '0; state_next = S_C1_ITER;
      end
      S_C1_ITER: begin
        cmd.op = OP_CITER;
        if (last_step) begin
          cnt_next = '0; state_next = S_C1_FIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_C1_FIN: begin
        cmd.op = OP_CFIN; state_next = S_MX0;
      end
      S_MX0: begin
        cmd.op = OP_MUL; cmd.a_sel = A_SUM; cmd.b_sel = B_COS; cmd.clear = 1'b1;
        state_next = S_MX1;
      end
      S_MX1: begin
        cmd.op = OP_MUL; cmd.a_sel = A_SUM; cmd.b_sel = B_COS; cmd.chunk = 2'd1;
        state_next = S_MOVEX;
      end
      S_MOVEX: begin
        cmd.op = OP_MOVE_X; state_next = S_MY0;
      end
      S_MY0: begin
        cmd.op = OP_MUL; cmd.a_sel = A_SUM; cmd.b_sel = B_SIN; cmd.clear = 1'b1;
        state_next = S_MY1;
      end
      S_MY1: begin
        cmd.op = OP_MUL; cmd.a_sel = A_SUM; cmd.b_sel = B_SIN; cmd.chunk = 2'd1;
        state_next = S_MOVEY;
      end
      S_MOVEY: begin
        cmd.op = OP_MOVE_Y; state_next = S_P0;
      end
      S_P0: begin
        cmd.op = OP_MUL; cmd.a_sel = A_DIFF; cmd.b_sel = B_IBW; cmd.clear = 1'b1;
        state_next = S_P1;
      end
      S_P1: begin
        cmd.op = OP_MUL; cmd.a_sel = A_DIFF; cmd.b_sel = B_IBW; cmd.chunk = 2'd1;
        state_next = S_SAVEP;
      end
      S_SAVEP: begin
        cmd.op = OP_SAVE_P; state_next = S_H0;
      end
      S_H0: begin
        cmd.op = OP_MUL; cmd.a_sel = A_HQ; cmd.b_sel = B_BAM; cmd.clear = 1'b1;
        state_next = S_H1;
      end
      S_H1: begin
        cmd.op = OP_MUL; cmd.a_sel = A_HQ; cmd.b_sel = B_BAM; cmd.chunk = 2'd1;
        state_next = S_HEAD;
      end
      S_HEAD: begin
        cmd.op = OP_HEAD; state_next = S_L0;
      end
      S_L0: begin
        cmd.op = OP_MUL; cmd.a_sel = A_SUM; cmd.b_sel = B_IP; cmd.clear = 1'b1;
        state_next = S_L1;
      end
      S_L1: begin
        cmd.op = OP_MUL; cmd.a_sel = A_SUM; cmd.b_sel = B_IP; cmd.chunk = 2'd1;
        state_next = S_LIN;
      end
      S_LIN: begin
        cmd.op = OP_LIN; state_next = S_A0;
      end
      S_A0: begin
        cmd.op = OP_MUL; cmd.a_sel = A_P; cmd.b_sel = B_IP; cmd.clear = 1'b1;
        state_next = S_A1;
      end
      S_A1: begin
        cmd.op = OP_MUL; cmd.a_sel = A_P; cmd.b_sel = B_IP; cmd.chunk = 2'd1;
        state_next = S_A2;
      end
      S_A2: begin
        cmd.op = OP_MUL; cmd.a_sel = A_P; cmd.b_sel = B_IP; cmd.chunk = 2'd2;
        state_next = S_ANG;
      end
      S_ANG: begin
        cmd.op = OP_ANG; state_next = S_C2_INIT;
      end
      S_C2_INIT: begin
        cmd.op = OP_CINIT; cmd.cnew = 1'b1; cnt_next = '0; state_next = S_C2_ITER;
      end
      S_C2_ITER: begin
        cmd.op = OP_CITER;
        if (last_step) begin
          cnt_next = '0; state_next = S_C2_FIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_C2_FIN: begin
        cmd.op = OP_CFIN; state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.slot_free) begin
          cmd.op = OP_EMIT; state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/ddo_datapath.sv -----
// Odometry datapath: pose state, shared multiplier, CORDIC rotator, result register.
module ddo_datapath import ddo_pkg::*; #(
  parameter int POSITION_BITS = DDO_POSITION_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  ddo_in_t     sample,
  input  ddo_cmd_t    cmd,
  output ddo_status_t status,
  output logic        pose_valid,
  input  logic        pose_stall,
  output ddo_out_t    pose
);

  localparam int PB = POSITION_BITS;

  logic [23:0] dpc, ibw, ip;
  logic [31:0] last_left, last_right, acc_heading;
  logic [PB-1:0] acc_x, acc_y;

  logic [31:0]        dl, dr;
  logic signed [56:0] dist_l, dist_r, sum, diff;
  logic [56:0]        sum_mag, diff_mag;
  logic [80:0]        p_r;
  logic [63:0]        hq_r;
  logic [127:0]       prod;
  logic signed [31:0] cos_r, sin_r, lin_r, ang_r;
  logic signed [33:0] cx, cy;
  logic signed [32:0] cz;
  logic [1:0]         quad;

  function automatic logic [31:0] sat_rate(input logic neg, input logic over,
                                           input logic [46:0] mag);
    logic [31:0] r;
    if (neg) begin
      if (over || mag > 47'h0_8000_0000) r = 32'h8000_0000;
      else r = 32'(-mag);
    end else begin
      if (over || mag > 47'h0_7FFF_FFFF) r = 32'h7FFF_FFFF;
      else r = mag[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [33:0] clamp30(input logic signed [33:0] v);
    logic signed [33:0] r;
    if (v > 34'(ONE_Q30)) r = 34'(ONE_Q30);
    else if (v < -34'(ONE_Q30)) r = -34'(ONE_Q30);
    else r = v;
    return r;
  endfunction

  // Combinational helpers
  logic signed [56:0] dist_mul;
  logic [95:0]        a_src;
  logic [31:0]        a_part, b_part;
  logic [127:0]       pp_shift;
  logic [30:0]        cos_mag, sin_mag;
  logic [127:0]       rnd;
  logic [PB-1:0]      move_mag;
  logic [31:0]        c_ang, c_a;
  logic signed [33:0] xs, ys, xc, yc;
  logic [63:0]        head_t;
  logic signed [63:0] ext_x, ext_y;

  assign sum_mag  = sum[56] ? 57'(-sum) : 57'(sum);
  assign diff_mag = diff[56] ? 57'(-diff) : 57'(diff);
  assign cos_mag  = cos_r[31] ? 31'(-cos_r) : 31'(cos_r);
  assign sin_mag  = sin_r[31] ? 31'(-sin_r) : 31'(sin_r);

  always_comb begin
    dist_mul = (cmd.op == OP_DIST_L) ? $signed(dl) * $signed({1'b0, dpc})
                                     : $signed(dr) * $signed({1'b0, dpc});
    case (cmd.a_sel)
      A_SUM:   a_src = 96'(sum_mag);
      A_DIFF:  a_src = 96'(diff_mag);
      A_P:     a_src = 96'(p_r);
      default: a_src = 96'(hq_r);
    endcase
    case (cmd.b_sel)
      B_COS:   b_part = 32'(cos_mag);
      B_SIN:   b_part = 32'(sin_mag);
      B_IBW:   b_part = 32'(ibw);
      B_BAM:   b_part = BAM_PER_RAD;
      default: b_part = 32'(ip);
    endcase
    a_part   = a_src[{cmd.chunk, 5'd0} +: 32];
    pp_shift = {64'd0, {32'd0, a_part} * {32'd0, b_part}} << {cmd.chunk, 5'd0};
    rnd      = prod + 128'h4000_0000;
    move_mag = rnd[31 +: PB];
    head_t   = prod[63:0] + 64'h8000_0000;
    c_ang    = cmd.cnew ? {1'b0, acc_heading[31:1]} : acc_heading;
    c_a      = c_ang + 32'h2000_0000;
    xs       = cx >>> cmd.step;
    ys       = cy >>> cmd.step;
    xc       = clamp30(cx);
    yc       = clamp30(cy);
    ext_x    = 64'($signed(acc_x));
    ext_y    = 64'($signed(acc_y));
  end

  assign status.slot_free = !pose_valid || !pose_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      dpc         <= DPC_RESET;
      ibw         <= IBW_RESET;
      ip          <= IP_RESET;
      last_left   <= '0;
      last_right  <= '0;
      acc_x       <= '0;
      acc_y       <= '0;
      acc_heading <= '0;
      pose_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DPC: dpc <= cfg_data;
          REG_IBW: ibw <= cfg_data;
          REG_IP:  ip  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.op == OP_LOAD) begin
        last_left  <= sample.left_count;
        last_right <= sample.right_count;
      end
      if (cmd.op == OP_MOVE_X)
        acc_x <= acc_x + ((sum[56] ^ cos_r[31]) ? PB'(-move_mag) : move_mag);
      if (cmd.op == OP_MOVE_Y)
        acc_y <= acc_y + ((sum[56] ^ sin_r[31]) ? PB'(-move_mag) : move_mag);
      if (cmd.op == OP_HEAD)
        acc_heading <= head_t[63:32];
      if (cmd.op == OP_EMIT) pose_valid <= 1'b1;
      else if (!pose_stall) pose_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        dl <= sample.left_count - last_left;
        dr <= sample.right_count - last_right;
      end
      OP_DIST_L: dist_l <= dist_mul;
      OP_DIST_R: dist_r <= dist_mul;
      OP_SUMDIFF: begin
        sum  <= dist_r + dist_l;
        diff <= dist_r - dist_l;
      end
      OP_CINIT: begin
        quad <= c_a[31:30];
        cz   <= $signed({3'b000, c_a[29:0]}) - 33'sd536870912;
        cx   <= 34'(CORDIC_GAIN);
        cy   <= '0;
      end
      OP_CITER: begin
        if (!cz[32]) begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - $signed({1'b0, atan_bam(cmd.step)});
        end else begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + $signed({1'b0, atan_bam(cmd.step)});
        end
      end
      OP_CFIN: begin
        case (quad)
          2'd0: begin cos_r <= 32'(xc);  sin_r <= 32'(yc);  end
          2'd1: begin cos_r <= 32'(-yc); sin_r <= 32'(xc);  end
          2'd2: begin cos_r <= 32'(-xc); sin_r <= 32'(-yc); end
          default: begin cos_r <= 32'(yc); sin_r <= 32'(-xc); end
        endcase
      end
      OP_MUL: prod <= (cmd.clear ? 128'd0 : prod) + pp_shift;
      OP_SAVE_P: begin
        p_r  <= prod[80:0];
        hq_r <= diff[56] ? 64'(-prod[63:0]) : prod[63:0];
      end
      OP_LIN: lin_r <= sat_rate(sum[56], |prod[127:64], prod[63:17]);
      OP_ANG: ang_r <= sat_rate(diff[56], |prod[127:64], {15'd0, prod[63:32]});
      OP_EMIT: begin
        pose.pos_x        <= ext_x[47:0];
        pose.pos_y        <= ext_y[47:0];
        pose.heading      <= acc_heading;
        pose.quat_z       <= sin_r;
        pose.quat_w       <= cos_r;
        pose.linear_rate  <= lin_r;
        pose.angular_rate <= ang_r;
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/differential_drive_odometry.sv -----
// Top level of the differential drive wheel odometry block.
// One sample is in flight at a time: sample_stall holds off the next one until the pose is
//   emitted, after two passes through the shared CORDIC rotator plus the sequence of
//   32x32 partial products on one multiplier.
// A finished pose waits in its output register while the next sample is taken.
// Reset (rst, synchronous): pose and counts cleared, registers to defaults, no pose pending.
module differential_drive_odometry import ddo_pkg::*; #(
  parameter int CORDIC_STEPS  = DDO_CORDIC_STEPS,
  parameter int POSITION_BITS = DDO_POSITION_BITS
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  // encoder sample channel
  input  logic        sample_valid,
  output logic        sample_stall,
  input  ddo_in_t     sample,
  // pose result channel
  output logic        pose_valid,
  input  logic        pose_stall,
  output ddo_out_t    pose
);

  ddo_cmd_t    cmd;
  ddo_status_t status;

  // Sequencer: holds off new samples while one is in flight, steps the datapath
  // through deltas, CORDIC of the old heading, position and heading update,
  // rate products, then CORDIC of the half new heading for the quaternion.
  ddo_ctrl #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .status       (status),
    .cmd          (cmd)
  );

  // Datapath: pose and configuration state, arithmetic and the output register.
  ddo_datapath #(
    .POSITION_BITS (POSITION_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample     (sample),
    .cmd        (cmd),
    .status     (status),
    .pose_valid (pose_valid),
    .pose_stall (pose_stall),
    .pose       (pose)
  );

  // An accepted sample transaction always starts the busy sequence.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall)
    else $error("sample accepted but sequencer not busy");

  // A new pose only appears at the end of a busy sequence.
  a_pose_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(pose_valid) |-> $past(sample_stall))
    else $error("pose raised without a sample in flight");

  // Leaving the busy sequence always leaves a pose pending.
  a_done_has_pose: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(sample_stall) |-> pose_valid)
    else $error("sequence ended without a pose");

  // The datapath only loads the result register when the slot is free.
  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_EMIT |-> status.slot_free)
    else $error("pose overwritten while still pending");

endmodule

// ----- verif/differential_drive_odometry_tb.sv -----
// Self-checking testbench for the differential drive odometry block.
module differential_drive_odometry_tb import ddo_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Index with no register behind it; writes to it must be dropped.
  localparam logic [1:0] REG_UNUSED = 2'd3;
  // Cycles the block may still be busy after the last pose: latency plus margin.
  localparam int SETTLE_CYCLES = 2 * DDO_CORDIC_STEPS + 60;

  // arctan(2^-i) in binary angle units, 2^32 per turn
  localparam longint ARCTAN_BAM [0:31] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_DPC;
  logic [23:0] cfg_data = '0;
  logic        sample_valid = 1'b0;
  logic        sample_stall;
  ddo_in_t     sample = '0;
  logic        pose_valid;
  logic        pose_stall = 1'b0;
  ddo_out_t    pose;

  differential_drive_odometry dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .sample_valid, .sample_stall, .sample,
    .pose_valid, .pose_stall, .pose
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Model state: registers, last counts and the pose accumulators.
  logic [23:0] dist_per_count, inv_wheel_base, inv_period;
  logic [31:0] prev_left, prev_right, heading_acc;
  logic [47:0] x_acc, y_acc;

  ddo_out_t expected_poses[$];
  int  error_count = 0;
  int  samples_sent = 0;
  int  poses_checked = 0;
  int  config_writes = 0;
  bit  no_idle = 1'b0;   // when set, neither side inserts gaps or stalls

  // Rotate the gain vector to a binary angle; returns cos and sin in Q2.30.
  function automatic void rotate(input logic [31:0] ang, output longint c,
                                 output longint s);
    logic [31:0] a;
    logic [1:0]  quadrant;
    longint x, y, z, xs, ys;
    a = ang + 32'h2000_0000;
    quadrant = a[31:30];
    z = $signed({34'b0, a[29:0]}) - 64'sd536870912;
    x = CORDIC_GAIN;
    y = 0;
    for (int i = 0; i < DDO_CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - ARCTAN_BAM[i];
      end else begin
        x = x + ys; y = y - xs; z = z + ARCTAN_BAM[i];
      end
    end
    if (x > ONE_Q30) x = ONE_Q30;
    if (x < -ONE_Q30) x = -ONE_Q30;
    if (y > ONE_Q30) y = ONE_Q30;
    if (y < -ONE_Q30) y = -ONE_Q30;
    case (quadrant)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic logic [63:0] magnitude(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // Travel (twice the mean, 2^-16 m) times a Q2.30 trig value, rounded, over 2^31.
  function automatic logic [63:0] travel_step(input longint travel, input longint trig);
    logic [127:0] p;
    logic [63:0]  m;
    p = {64'b0, magnitude(travel)} * {64'b0, magnitude(trig)} + (128'd1 << 30);
    m = p[94:31];
    return ((travel < 0) != (trig < 0)) ? -m : m;
  endfunction

  function automatic logic [31:0] clamp_rate(input bit neg, input bit over,
                                             input logic [63:0] mag);
    if (neg) begin
      if (over || mag > 64'h8000_0000) return 32'h8000_0000;
      return 32'(-mag);
    end
    if (over || mag > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return mag[31:0];
  endfunction

  // Advance the pose by one encoder sample and build the expected pose.
  function automatic ddo_out_t advance_pose(input ddo_in_t s);
    ddo_out_t r;
    logic signed [31:0] dl32, dr32;
    longint dl, dr, travel_sum, travel_diff, c, sn;
    logic [63:0]  q, rounded, big;
    logic [127:0] p, p2;
    dl32 = s.left_count - prev_left;
    dr32 = s.right_count - prev_right;
    dl = dl32;
    dr = dr32;
    travel_sum  = dr * $signed({40'b0, dist_per_count}) + dl * $signed({40'b0, dist_per_count});
    travel_diff = dr * $signed({40'b0, dist_per_count}) - dl * $signed({40'b0, dist_per_count});
    prev_left = s.left_count;
    prev_right = s.right_count;

    // move along the heading held before this sample
    rotate(heading_acc, c, sn);
    x_acc = x_acc + 48'(travel_step(travel_sum, c));
    y_acc = y_acc + 48'(travel_step(travel_sum, sn));

    q = 64'(travel_diff) * {40'b0, inv_wheel_base};
    q = q * {32'b0, BAM_PER_RAD};
    rounded = q + 64'h8000_0000;
    heading_acc = rounded[63:32];

    r.pos_x = x_acc;
    r.pos_y = y_acc;
    r.heading = heading_acc;
    rotate(heading_acc >> 1, c, sn);
    r.quat_z = sn[31:0];
    r.quat_w = c[31:0];

    p = {64'b0, magnitude(travel_sum)} * {104'b0, inv_period};
    r.linear_rate = clamp_rate(travel_sum < 0, p[127:64] != 0, p[63:0] >> 17);

    p  = {64'b0, magnitude(travel_diff)} * {104'b0, inv_wheel_base};
    p2 = {64'b0, p[63:0]} * {104'b0, inv_period};
    big = p[127:64] * {40'b0, inv_period} + p2[127:64];
    r.angular_rate = clamp_rate(travel_diff < 0, big != 0, p2[63:0] >> 32);
    return r;
  endfunction

  // Offer one sample transaction after a random gap; predict on acceptance.
  task automatic send_sample(input logic [31:0] left, input logic [31:0] right);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= '{left_count: left, right_count: right};
    do @(posedge clk); while (sample_stall);
    expected_poses.push_back(advance_pose('{left_count: left, right_count: right}));
    samples_sent++;
  endtask

  // Let every pending pose drain and the block settle back to idle.
  task automatic drain();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (expected_poses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [23:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      REG_DPC: dist_per_count = value;
      REG_IBW: inv_wheel_base = value;
      REG_IP:  inv_period = value;
      default: ;  // unmapped index: drop the write
    endcase
    config_writes++;
  endtask

  task automatic configure(input logic [23:0] dpc, input logic [23:0] ibw,
                           input logic [23:0] ip);
    drain();
    write_reg(REG_DPC, dpc);
    write_reg(REG_IBW, ibw);
    write_reg(REG_IP, ip);
  endtask

  // Result side: after each pose transaction draw a hold count and stall the
  // next pose for that many cycles once it shows up.
  int stall_left = 0;
  always @(posedge clk) begin
    int hold;
    if (rst) begin
      pose_stall <= 1'b0;
      stall_left <= 0;
    end else if (pose_valid && !pose_stall) begin
      hold = no_idle ? 0 : $urandom_range(0, 3);
      stall_left <= hold;
      pose_stall <= (hold > 0);
    end else if (pose_valid && pose_stall) begin
      if (stall_left > 1) begin
        stall_left <= stall_left - 1;
      end else begin
        stall_left <= 0;
        pose_stall <= 1'b0;
      end
    end
  end

  task automatic report(input string field, input logic [63:0] exp_v,
                        input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, exp_v, act_v);
      error_count++;
    end
  endtask

  // Compare each pose transaction against the oldest prediction.
  always @(posedge clk) begin
    ddo_out_t e;
    if (!rst && pose_valid && !pose_stall) begin
      if (expected_poses.size() == 0) begin
        $display("%0t: unexpected pose, expected none actual %h", $time, pose);
        error_count++;
      end else begin
        e = expected_poses.pop_front();
        report("pos_x", e.pos_x, pose.pos_x);
        report("pos_y", e.pos_y, pose.pos_y);
        report("heading", e.heading, pose.heading);
        report("quat_z", e.quat_z, pose.quat_z);
        report("quat_w", e.quat_w, pose.quat_w);
        report("linear_rate", e.linear_rate, pose.linear_rate);
        report("angular_rate", e.angular_rate, pose.angular_rate);
        poses_checked++;
      end
    end
  end

  // Extremes of the counts, wrap of the deltas and big jumps at reset values.
  task automatic test_count_extremes();
    send_sample(32'd0, 32'd0);
    send_sample(32'd100, 32'd100);
    send_sample(32'd150, 32'd300);
    send_sample(32'd120, 32'd900);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF);
    send_sample(32'hFFFF_FFFF, 32'h0000_0000);
    send_sample(32'h0000_0001, 32'hFFFF_FFFE);
    send_sample(32'h5555_5555, 32'hAAAA_AAAA);
    send_sample(32'hAAAA_AAAA, 32'h5555_5555);
  endtask

  // Register extremes: saturating rates, zero wheel base, zero rate, unmapped index.
  task automatic test_register_extremes();
    configure(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
    send_sample(32'h4000_0000, 32'hC000_0000);
    send_sample(32'h4000_0010, 32'hC000_0000);
    send_sample(32'h4000_0010, 32'hC000_0100);
    configure(24'd41177, 24'd0, 24'hFF_FFFF);
    send_sample(32'd5000, 32'd9000);
    send_sample(32'd2000, 32'd1000);
    configure(24'd0, 24'd1, 24'd0);
    send_sample(32'h1234_5678, 32'h8765_4321);
    configure(24'd65536, 24'd131072, 24'd0);
    send_sample(32'h0000_1000, 32'h0000_3000);
    drain();
    write_reg(REG_UNUSED, 24'hAB_CDEF);
    send_sample(32'h0000_1100, 32'h0000_3300);
    configure(DPC_RESET, IBW_RESET, IP_RESET);
    send_sample(32'h0000_1200, 32'h0000_3800);
  endtask

  // Random driving: mostly smooth wheel motion, some raw count noise.
  task automatic test_random_motion(input int count);
    logic [31:0] left, right;
    int step_size;
    left = prev_left;
    right = prev_right;
    step_size = 1 << $urandom_range(2, 18);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 19) == 0) begin
        left = $urandom;
        right = $urandom;
      end else begin
        left = left + $signed($urandom_range(0, 2 * step_size)) - step_size;
        right = right + $signed($urandom_range(0, 2 * step_size)) - step_size;
      end
      send_sample(left, right);
    end
  endtask

  task automatic test_random_phases();
    logic [23:0] dpc, ibw, ip;
    for (int phase = 0; phase < 12; phase++) begin
      dpc = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(1, 200000));
      ibw = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(1, 1000000));
      ip  = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 2000000));
      configure(dpc, ibw, ip);
      no_idle = (phase % 4 == 3);
      test_random_motion(100);
      no_idle = 1'b0;
      // hold off mid phase until every pose has come back
      if (phase == 5) begin
        drain();
      end
      test_random_motion(15);
    end
  endtask

  initial begin
    dist_per_count = DPC_RESET;
    inv_wheel_base = IBW_RESET;
    inv_period = IP_RESET;
    prev_left = '0;
    prev_right = '0;
    heading_acc = '0;
    x_acc = '0;
    y_acc = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_count_extremes();
    test_register_extremes();
    test_random_phases();
    drain();

    $display("Covered %0d samples, %0d poses checked, %0d register writes,",
             samples_sent, poses_checked, config_writes);
    $display("including rate saturation, zero wheel base, zero rate and count wrap.");
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d poses outstanding", expected_poses.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- differential_drive_odometry.f -----
rtl/ddo_pkg.sv
rtl/ddo_ctrl.sv
rtl/ddo_datapath.sv
rtl/differential_drive_odometry.sv
verif/differential_drive_odometry_tb.sv
